[rtl/rdc_pkg.sv]
// Shared types, constants and helpers for the radix digit converter.
// Used by every module under rtl/ except rdc_ram; depends on nothing else.
package rdc_pkg;

  localparam int unsigned SYM_COUNT = 16;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] MAX_SYMBOLS   = 5'd16;
  localparam logic [SYM_W-1:0] PRINTABLE_MIN = 8'd32;
  localparam logic [SYM_W-1:0] MINUS_CHAR    = 8'h2D;
  localparam logic [SYM_W-1:0] PLUS_CHAR     = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POW,
    ST_RD,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic done;
    logic bad;
  } chk_status_t;

  function automatic logic [SYM_W-1:0] symbol_at(input logic [CFG_W-1:0] lo,
                                                 input logic [CFG_W-1:0] hi,
                                                 input logic [DIGIT_W-1:0] k);
    logic [2*CFG_W-1:0] all;
    all = {hi, lo};
    return all[k*SYM_W +: SYM_W];
  endfunction

endpackage

[rtl/rdc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module rdc_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

endmodule

[rtl/rdc_alpha_check.sv]
// Alphabet checker: walks the symbols in use one per cycle and compares each
// against all later symbols at once. Depends on rdc_pkg.
module rdc_alpha_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rdc_pkg::CFG_W-1:0]     alpha_lo,
  input  logic [rdc_pkg::CFG_W-1:0]     alpha_hi,
  input  logic [rdc_pkg::LEN_W-1:0]     alpha_len,
  output rdc_pkg::chk_status_t          status
);
  import rdc_pkg::*;

  logic               busy_r, busy_nxt;
  logic [DIGIT_W-1:0] idx_r, idx_nxt;
  logic               done_r, done_nxt;
  logic               bad_r, bad_nxt;

  logic [SYM_W-1:0] syms [SYM_COUNT];
  logic [SYM_W-1:0] cur;
  logic             dup;
  logic             hit;
  logic             at_end;

  always_comb begin
    for (int b = 0; b < SYM_COUNT; b++) begin
      syms[b] = symbol_at(alpha_lo, alpha_hi, DIGIT_W'(b));
    end
    cur = syms[idx_r];
    dup = 1'b0;
    for (int b = 0; b < SYM_COUNT; b++) begin
      if ((DIGIT_W'(b) > idx_r) && (LEN_W'(b) < alpha_len) && (syms[b] == cur)) begin
        dup = 1'b1;
      end
    end
    hit    = (cur < PRINTABLE_MIN) || (cur == MINUS_CHAR) || (cur == PLUS_CHAR) || dup;
    at_end = ({1'b0, idx_r} == (alpha_len - 5'd1));
  end

  always_comb begin
    done_nxt = 1'b0;
    bad_nxt  = bad_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start) begin
      if ((alpha_len < 5'd2) || (alpha_len > MAX_SYMBOLS)) begin
        done_nxt = 1'b1;
        bad_nxt  = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        idx_nxt  = '0;
      end
    end else if (busy_r) begin
      if (hit) begin
        done_nxt = 1'b1;
        bad_nxt  = 1'b1;
        busy_nxt = 1'b0;
      end else if (at_end) begin
        done_nxt = 1'b1;
        bad_nxt  = 1'b0;
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bad_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bad_r  <= bad_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign status.done = done_r;
  assign status.bad  = bad_r;

endmodule

[rtl/rdc_quot_unit.sv]
// Shared compare-subtract unit: finds a 4-bit quotient of the running value
// by a radix power, one quotient bit per cycle. Depends on rdc_pkg.
module rdc_quot_unit #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [VALUE_BITS-1:0]       dividend,
  input  logic [VALUE_BITS-1:0]       divisor,
  output logic                        done,
  output logic [rdc_pkg::DIGIT_W-1:0] quotient,
  output logic [VALUE_BITS-1:0]       remainder
);
  import rdc_pkg::*;

  localparam int unsigned WIDE = VALUE_BITS + DIGIT_W;

  logic                  busy_r;
  logic                  done_r;
  logic [1:0]            j_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] div_r;
  logic [DIGIT_W-1:0]    q_r;

  logic [WIDE-1:0] trial;
  logic            fits;

  assign trial = {{DIGIT_W{1'b0}}, div_r} << j_r;
  assign fits  = ({{DIGIT_W{1'b0}}, rem_r} >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      j_r    <= '0;
    end else begin
      done_r <= busy_r && !start && (j_r == 2'd0);
      if (start) begin
        busy_r <= 1'b1;
        j_r    <= 2'd3;
      end else if (busy_r) begin
        j_r <= j_r - 2'd1;
        if (j_r == 2'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      div_r <= divisor;
      q_r   <= '0;
    end else if (busy_r && fits) begin
      rem_r    <= rem_r - trial[VALUE_BITS-1:0];
      q_r[j_r] <= 1'b1;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

[rtl/radix_digit_converter.sv]
// Top level of the radix digit converter: configuration registers, sequencer,
// power table RAM, alphabet checker and shared quotient unit. Depends on rdc_pkg.
//
//   channel | direction | handshake              | payload
//   in_     | slave     | in_tvalid / in_tready   | in_tdata = value
//   out_    | master    | out_tvalid / out_tready | tdata = digit_char, tlast, tuser
//   cfg_    | write     | cfg_we                  | cfg_index, cfg_wdata
//
// One value at a time; in_tready is high only while idle.
// The alphabet checker rejects a bad length without walking the symbols.
// The power table is built one entry per digit; then each digit takes a RAM read, a load,
// four quotient steps, the unit's done flag and the output transfer, in that order.
// A stalled result holds the sequencer. Synchronous active-low reset clears control state.
module radix_digit_converter #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     in_tdata,   // value, zero padded
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rdc_pkg::SYM_W-1:0]           out_tdata,  // digit_char
  output logic                                out_tlast,
  output logic                                out_tuser,  // bad_alphabet
  input  logic                                cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdc_pkg::CFG_W-1:0]           cfg_wdata
);
  import rdc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(VALUE_BITS);
  localparam int unsigned PROD_W = VALUE_BITS + LEN_W;

  logic [CFG_W-1:0] alpha_lo_r, alpha_hi_r;
  logic [LEN_W-1:0] alpha_len_r;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [VALUE_BITS-1:0] p_r, p_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [SYM_W-1:0]      odata_r, odata_nxt;
  logic                  olast_r, olast_nxt;
  logic                  ouser_r, ouser_nxt;

  logic                  chk_start;
  chk_status_t           chk;
  logic                  q_start;
  logic                  q_done;
  logic [DIGIT_W-1:0]    q_digit;
  logic [VALUE_BITS-1:0] q_rem;
  logic                  ram_we;
  logic [VALUE_BITS-1:0] ram_rd_data;
  logic [PROD_W-1:0]     prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo_r  <= '0;
      alpha_hi_r  <= '0;
      alpha_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHABET_LOW:    alpha_lo_r  <= cfg_wdata;
        REG_ALPHABET_HIGH:   alpha_hi_r  <= cfg_wdata;
        REG_ALPHABET_LENGTH: alpha_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  rdc_alpha_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (chk_start),
    .alpha_lo  (alpha_lo_r),
    .alpha_hi  (alpha_hi_r),
    .alpha_len (alpha_len_r),
    .status    (chk)
  );

  // Powers of the radix, lowest first; read back from the top down.
  rdc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (VALUE_BITS)
  ) u_pow_ram (
    .clk       (clk),
    .we        (ram_we),
    .waddr     (idx_r),
    .wdata     (p_r),
    .raddr     (idx_r),
    .rd_data_r (ram_rd_data)
  );

  rdc_quot_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_quot (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (q_start),
    .dividend  (v_r),
    .divisor   (ram_rd_data),
    .done      (q_done),
    .quotient  (q_digit),
    .remainder (q_rem)
  );

  assign prod = PROD_W'(p_r) * PROD_W'(alpha_len_r);

  always_comb begin
    state_nxt  = state_r;
    v_nxt      = v_r;
    p_nxt      = p_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    ouser_nxt  = ouser_r;
    chk_start  = 1'b0;
    q_start    = 1'b0;
    ram_we     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          v_nxt     = in_tdata[VALUE_BITS-1:0];
          chk_start = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk.done) begin
          if (chk.bad) begin
            odata_nxt  = '0;
            olast_nxt  = 1'b1;
            ouser_nxt  = 1'b1;
            ovalid_nxt = 1'b1;
            state_nxt  = ST_OUT;
          end else begin
            p_nxt     = {{(VALUE_BITS-1){1'b0}}, 1'b1};
            idx_nxt   = '0;
            state_nxt = ST_POW;
          end
        end
      end
      ST_POW: begin
        ram_we = 1'b1;
        // Stop once the next power exceeds the value; idx_r is then the top digit.
        if (prod > {{LEN_W{1'b0}}, v_r}) begin
          state_nxt = ST_RD;
        end else begin
          p_nxt   = prod[VALUE_BITS-1:0];
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        q_start   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (q_done) begin
          v_nxt      = q_rem;
          odata_nxt  = symbol_at(alpha_lo_r, alpha_hi_r, q_digit);
          olast_nxt  = (idx_r == '0);
          ouser_nxt  = 1'b0;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    p_r     <= p_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    ouser_r <= ouser_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

endmodule
